/* hw/rtl/pbwt_pkg.sv */
package pbwt_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [1:0]  status;
    logic        end_of_message;
  } out_word_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

  function automatic logic [63:0] varint_bits(input logic [3:0] idx, input logic [7:0] b);
    logic [63:0] ext;
    ext = {57'd0, b[6:0]};
    if (idx < VARINT_LAST_IDX) begin
      varint_bits = ext << (7'(idx) * 7'd7);
    end else if (idx == VARINT_LAST_IDX) begin
      varint_bits = {b[0], 63'd0};
    end else begin
      varint_bits = 64'd0;
    end
  endfunction

endpackage

/* hw/rtl/pbwt_in_stage.sv */
module pbwt_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pbwt_pkg::in_word_t in_data,
  input  logic               advance,
  output logic               held_valid,
  output pbwt_pkg::in_word_t held_data
);

  logic               v_r, v_nxt;
  pbwt_pkg::in_word_t d_r;
  logic               take;

  assign in_stall   = v_r && !advance;
  assign take       = in_valid && !in_stall;
  assign held_valid = v_r;
  assign held_data  = d_r;

  always_comb begin
    v_nxt = v_r;
    if (take) begin
      v_nxt = 1'b1;
    end else if (advance) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      d_r <= in_data;
    end
  end

endmodule

/* hw/rtl/pbwt_parse.sv */
module pbwt_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  pbwt_pkg::in_word_t  word,
  output logic                res_valid,
  output pbwt_pkg::out_word_t res
);

  localparam logic [2:0] PH_KEY     = 3'd0;
  localparam logic [2:0] PH_VARINT  = 3'd1;
  localparam logic [2:0] PH_FIXED   = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] fld_r, fld_nxt;
  logic [2:0]  typ_r, typ_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic        disc_r, disc_nxt;

  logic [7:0]  b;
  logic        last;
  logic [63:0] acc_fix;
  logic [63:0] acc_var;
  logic [63:0] rem_dec;
  logic        fix_done;
  logic        clear;
  logic [31:0] key_fld;
  logic [2:0]  key_typ;

  assign b        = word.data_byte;
  assign last     = word.last_byte;
  assign acc_fix  = acc_r | ({56'd0, b} << {cnt_r[2:0], 3'b000});
  assign acc_var  = acc_r | pbwt_pkg::varint_bits(cnt_r, b);
  assign rem_dec  = rem_r - 64'd1;
  assign fix_done = cnt_r[2:0] == ((typ_r == pbwt_pkg::WT_FIXED64) ? 3'd7 : 3'd3);
  assign key_fld  = acc_var[34:3];
  assign key_typ  = acc_var[2:0];

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    fld_nxt   = fld_r;
    typ_nxt   = typ_r;
    rem_nxt   = rem_r;
    disc_nxt  = disc_r;
    clear     = 1'b0;
    res_valid = 1'b0;
    res.field_number   = fld_r;
    res.wire_kind      = typ_r;
    res.field_value    = 64'd0;
    res.status         = pbwt_pkg::ST_OK;
    res.end_of_message = last;

    if (go) begin
      if (disc_r) begin
        if (last) begin
          disc_nxt = 1'b0;
          clear    = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_FIXED: begin
            if (fix_done) begin
              res_valid       = 1'b1;
              res.field_value = acc_fix;
              clear           = 1'b1;
            end else if (last) begin
              res_valid  = 1'b1;
              res.status = pbwt_pkg::ST_TRUNCATED;
              clear      = 1'b1;
            end else begin
              acc_nxt = acc_fix;
              cnt_nxt = cnt_r + 4'd1;
            end
          end
          PH_PAYLOAD: begin
            if (rem_dec == 64'd0) begin
              res_valid       = 1'b1;
              res.field_value = acc_r;
              clear           = 1'b1;
            end else if (last) begin
              res_valid  = 1'b1;
              res.status = pbwt_pkg::ST_TRUNCATED;
              clear      = 1'b1;
            end else begin
              rem_nxt = rem_dec;
            end
          end
          default: begin
            if (b[7]) begin
              if (cnt_r == pbwt_pkg::VARINT_LAST_IDX) begin
                res_valid  = 1'b1;
                res.status = pbwt_pkg::ST_TOO_LONG;
                clear      = 1'b1;
                disc_nxt   = !last;
              end else if (last) begin
                res_valid  = 1'b1;
                res.status = pbwt_pkg::ST_TRUNCATED;
                clear      = 1'b1;
              end else begin
                acc_nxt = acc_var;
                cnt_nxt = cnt_r + 4'd1;
              end
            end else if (phase_r == PH_VARINT) begin
              res_valid       = 1'b1;
              res.field_value = acc_var;
              clear           = 1'b1;
            end else if (phase_r == PH_LENGTH) begin
              if (acc_var == 64'd0) begin
                res_valid = 1'b1;
                clear     = 1'b1;
              end else if (last) begin
                res_valid  = 1'b1;
                res.status = pbwt_pkg::ST_TRUNCATED;
                clear      = 1'b1;
              end else begin
                rem_nxt   = acc_var;
                acc_nxt   = acc_var;
                cnt_nxt   = 4'd0;
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              res.field_number = key_fld;
              res.wire_kind    = key_typ;
              if (key_typ != pbwt_pkg::WT_VARINT && key_typ != pbwt_pkg::WT_FIXED64 &&
                  key_typ != pbwt_pkg::WT_LENGTH && key_typ != pbwt_pkg::WT_FIXED32) begin
                res_valid  = 1'b1;
                res.status = pbwt_pkg::ST_BAD_TYPE;
                clear      = 1'b1;
                disc_nxt   = !last;
              end else if (last) begin
                res_valid  = 1'b1;
                res.status = pbwt_pkg::ST_TRUNCATED;
                clear      = 1'b1;
              end else begin
                fld_nxt = key_fld;
                typ_nxt = key_typ;
                acc_nxt = 64'd0;
                cnt_nxt = 4'd0;
                if (key_typ == pbwt_pkg::WT_VARINT) begin
                  phase_nxt = PH_VARINT;
                end else if (key_typ == pbwt_pkg::WT_LENGTH) begin
                  phase_nxt = PH_LENGTH;
                end else begin
                  phase_nxt = PH_FIXED;
                end
              end
            end
          end
        endcase
      end
    end

    if (clear) begin
      phase_nxt = PH_KEY;
      cnt_nxt   = 4'd0;
      acc_nxt   = 64'd0;
      fld_nxt   = 32'd0;
      typ_nxt   = 3'd0;
      rem_nxt   = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      cnt_r   <= 4'd0;
      acc_r   <= 64'd0;
      fld_r   <= 32'd0;
      typ_r   <= 3'd0;
      rem_r   <= 64'd0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      fld_r   <= fld_nxt;
      typ_r   <= typ_nxt;
      rem_r   <= rem_nxt;
      disc_r  <= disc_nxt;
    end
  end

  a_no_result_while_dropping: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> !res_valid)
    else $error("result while dropping");

  a_last_returns_to_key: assert property (@(posedge clk) disable iff (!rst_n)
    go && last |=> phase_r == PH_KEY && !disc_r && cnt_r == 4'd0)
    else $error("parser not idle after last word");

  a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != pbwt_pkg::ST_OK |=> phase_r == PH_KEY && acc_r == 64'd0)
    else $error("state kept after error");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status != pbwt_pkg::ST_OK |-> res.field_value == 64'd0)
    else $error("nonzero value on error");

endmodule

/* hw/rtl/pbwt_out_stage.sv */
module pbwt_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pbwt_pkg::out_word_t load_data,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output pbwt_pkg::out_word_t out_data
);

  logic                v_r, v_nxt;
  pbwt_pkg::out_word_t d_r;

  assign room      = !v_r || !out_stall;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_comb begin
    v_nxt = v_r;
    if (load) begin
      v_nxt = 1'b1;
    end else if (!out_stall) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= load_data;
    end
  end

endmodule

/* hw/rtl/protobuf_wire_field_tokenizer.sv */
// channel | handshake             | word
// input   | in_valid, in_stall    | in_data: data_byte, last_byte
// output  | out_valid, out_stall  | out_data: field_number, wire_kind, field_value, status, eom
// One byte per cycle while out_stall is low; out_valid is driven by the result register.
// Rate is set by the single parse step between the input and result registers.
// rst_n is synchronous: it empties both registers and returns the parser to key.
// A stalled full result register holds a full input register, so in_stall rises at once.
module protobuf_wire_field_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbwt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbwt_pkg::out_word_t out_data
);

  logic                held_valid;
  pbwt_pkg::in_word_t  held_data;
  logic                room;
  logic                advance;
  logic                res_valid;
  pbwt_pkg::out_word_t res;

  assign advance = held_valid && room;

  pbwt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  pbwt_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .word      (held_data),
    .res_valid (res_valid),
    .res       (res)
  );

  pbwt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb.sv */
module tb;

  typedef enum logic [2:0] {PH_KEY, PH_VARINT, PH_FIXED, PH_LENGTH, PH_PAYLOAD} parse_phase_t;
  typedef logic [7:0] byte_q_t[$];

  localparam logic [2:0] WT_UNUSED = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES = 200;

  class token_tracker;
    pbwt_pkg::out_word_t expected_tokens[$];
    int unsigned mismatches;
    parse_phase_t phase;
    logic [6:0] shift;
    logic [63:0] acc;
    logic [31:0] cur_field;
    logic [2:0] cur_type;
    logic [63:0] remain;
    logic discarding;

    function new();
      clear_parse();
      discarding = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_parse();
      phase = PH_KEY;
      shift = '0;
      acc = '0;
      cur_field = '0;
      cur_type = '0;
      remain = '0;
    endfunction

    function void push_token(logic [63:0] value, logic [1:0] st, logic eom);
      pbwt_pkg::out_word_t r;
      r.field_number = cur_field;
      r.wire_kind = cur_type;
      r.field_value = value;
      r.status = st;
      r.end_of_message = eom;
      expected_tokens.push_back(r);
      clear_parse();
    endfunction

    function void push_error(logic [1:0] st, logic last);
      push_token(64'd0, st, (st == pbwt_pkg::ST_TRUNCATED) ? 1'b1 : last);
      discarding = !last;
    endfunction

    function void note_byte(pbwt_pkg::in_word_t w);
      logic [7:0] b;
      logic last;
      b = w.data_byte;
      last = w.last_byte;
      if (discarding) begin
        if (last) begin
          clear_parse();
          discarding = 1'b0;
        end
        return;
      end
      case (phase)
        PH_FIXED: begin
          acc |= 64'(b) << shift[5:0];
          shift = shift + 7'd8;
          remain = remain - 64'd1;
          if (remain == 64'd0) push_token(acc, pbwt_pkg::ST_OK, last);
          else if (last) push_error(pbwt_pkg::ST_TRUNCATED, last);
        end
        PH_PAYLOAD: begin
          remain = remain - 64'd1;
          if (remain == 64'd0) push_token(acc, pbwt_pkg::ST_OK, last);
          else if (last) push_error(pbwt_pkg::ST_TRUNCATED, last);
        end
        default: begin
          if (shift < 7'd64) acc |= 64'(b[6:0]) << shift;
          if (b[7]) begin
            shift = shift + 7'd7;
            if (shift >= 7'd70) push_error(pbwt_pkg::ST_TOO_LONG, last);
            else if (last) push_error(pbwt_pkg::ST_TRUNCATED, last);
          end else if (phase == PH_KEY) begin
            cur_field = acc[34:3];
            cur_type = acc[2:0];
            acc = '0;
            shift = '0;
            case (cur_type)
              pbwt_pkg::WT_VARINT: phase = PH_VARINT;
              pbwt_pkg::WT_FIXED64: begin
                phase = PH_FIXED;
                remain = 64'd8;
              end
              pbwt_pkg::WT_FIXED32: begin
                phase = PH_FIXED;
                remain = 64'd4;
              end
              pbwt_pkg::WT_LENGTH: phase = PH_LENGTH;
              default: begin
                push_error(pbwt_pkg::ST_BAD_TYPE, last);
                return;
              end
            endcase
            if (last) push_error(pbwt_pkg::ST_TRUNCATED, last);
          end else if (phase == PH_VARINT) begin
            push_token(acc, pbwt_pkg::ST_OK, last);
          end else if (acc == 64'd0) begin
            push_token(64'd0, pbwt_pkg::ST_OK, last);
          end else if (last) begin
            push_error(pbwt_pkg::ST_TRUNCATED, last);
          end else begin
            remain = acc;
            shift = '0;
            phase = PH_PAYLOAD;
          end
        end
      endcase
    endfunction

    function void flag(string text);
      mismatches++;
      if (mismatches <= 10) $display("%s", text);
    endfunction

    function void check_token(pbwt_pkg::out_word_t got);
      pbwt_pkg::out_word_t exp;
      if (expected_tokens.size() == 0) begin
        flag($sformatf("unexpected word num=%h type=%0d value=%h status=%0d eom=%0d",
                       got.field_number, got.wire_kind, got.field_value, got.status,
                       got.end_of_message));
        return;
      end
      exp = expected_tokens.pop_front();
      if (got.field_number !== exp.field_number || got.wire_kind !== exp.wire_kind ||
          got.field_value !== exp.field_value || got.status !== exp.status ||
          got.end_of_message !== exp.end_of_message) begin
        flag($sformatf("mismatch exp %h/%0d/%h/%0d/%0d got %h/%0d/%h/%0d/%0d",
                       exp.field_number, exp.wire_kind, exp.field_value, exp.status,
                       exp.end_of_message, got.field_number, got.wire_kind,
                       got.field_value, got.status, got.end_of_message));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pbwt_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pbwt_pkg::out_word_t out_data;

  token_tracker board = new();
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;

  protobuf_wire_field_tokenizer i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_token(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic void put_varint(ref byte_q_t q, input logic [63:0] v,
                                     input int unsigned len);
    logic [63:0] rest;
    logic [7:0] b;
    logic more;
    rest = v;
    for (int n = 1; n <= 10; n++) begin
      b = {1'b0, rest[6:0]};
      // high bits of the tenth byte are dropped by the decoder
      if (n == 10) b[6:1] = 6'($urandom);
      rest = rest >> 7;
      more = (n < 10) && (rest != 64'd0 || n < len);
      b[7] = more;
      q.push_back(b);
      if (!more) break;
    end
  endfunction

  function automatic void put_key(ref byte_q_t q, input logic [31:0] fnum,
                                  input logic [2:0] wt);
    put_varint(q, {29'd0, fnum, wt}, 0);
  endfunction

  function automatic void put_fixed(ref byte_q_t q, input logic [63:0] v,
                                    input int unsigned n);
    for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_field(ref byte_q_t q, input logic [2:0] wt);
    logic [63:0] key;
    logic [63:0] len;
    int unsigned pad;
    key = {29'd0, 32'($urandom_range(1, 20)), wt};
    if ($urandom_range(3) == 0) key[34:3] = $urandom;
    if ($urandom_range(15) == 0) key[63:35] = 29'($urandom);
    pad = ($urandom_range(7) == 0) ? $urandom_range(1, 10) : 0;
    put_varint(q, key, pad);
    case (wt)
      pbwt_pkg::WT_VARINT: put_varint(q, rand_value(), pad);
      pbwt_pkg::WT_FIXED64: put_fixed(q, {$urandom, $urandom}, 8);
      pbwt_pkg::WT_FIXED32: put_fixed(q, 64'($urandom), 4);
      pbwt_pkg::WT_LENGTH: begin
        len = 64'($urandom_range(0, 5));
        if ($urandom_range(15) == 0) len = rand_value();
        put_varint(q, len, pad);
        put_fixed(q, {$urandom, $urandom}, (len > 64'd5) ? 3 : int'(len));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] good_type();
    case ($urandom_range(3))
      0: return pbwt_pkg::WT_VARINT;
      1: return pbwt_pkg::WT_FIXED64;
      2: return pbwt_pkg::WT_LENGTH;
      default: return pbwt_pkg::WT_FIXED32;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    pbwt_pkg::in_word_t w;
    w.data_byte = b;
    w.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.note_byte(w);
    bytes_sent++;
  endtask

  task automatic send_message(input byte_q_t q);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_tokens.size() != 0) @(posedge clk);
  endtask

  initial begin
    byte_q_t msg;
    int unsigned kind;
    int unsigned cut;
    logic [2:0] wt;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    msg = {};
    put_key(msg, 32'd1, pbwt_pkg::WT_VARINT);
    put_varint(msg, 64'd0, 0);
    put_key(msg, 32'hFFFF_FFFF, pbwt_pkg::WT_VARINT);
    put_varint(msg, '1, 0);
    put_key(msg, 32'd2, pbwt_pkg::WT_FIXED64);
    put_fixed(msg, '1, 8);
    put_key(msg, 32'd3, pbwt_pkg::WT_FIXED32);
    put_fixed(msg, 64'h8000_0001, 4);
    put_key(msg, 32'd4, pbwt_pkg::WT_LENGTH);
    put_varint(msg, 64'd0, 0);
    put_key(msg, 32'd5, pbwt_pkg::WT_LENGTH);
    put_varint(msg, 64'd2, 0);
    put_fixed(msg, 64'hA55A, 2);
    send_message(msg);

    msg = {};
    put_key(msg, 32'd7, WT_UNUSED);
    msg.push_back(8'hFF);
    msg.push_back(8'h00);
    send_message(msg);

    msg = {};
    repeat (10) msg.push_back(8'hFF);
    msg.push_back(8'h00);
    send_message(msg);

    msg = {};
    put_key(msg, 32'd6, pbwt_pkg::WT_FIXED32);
    put_fixed(msg, 64'hBEEF, 2);
    send_message(msg);

    msg = {};
    msg.push_back(8'h80);
    send_message(msg);

    msg = {};
    put_key(msg, 32'd1, WT_UNUSED);
    send_message(msg);

    msg = {};
    put_key(msg, 32'd1, pbwt_pkg::WT_VARINT);
    send_message(msg);

    msg = {};
    put_key(msg, 32'd9, pbwt_pkg::WT_LENGTH);
    put_varint(msg, 64'd5, 0);
    send_message(msg);

    msg = {};
    put_key(msg, 32'd9, pbwt_pkg::WT_LENGTH);
    put_varint(msg, 64'd3, 0);
    msg.push_back(8'h5A);
    send_message(msg);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 64;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      while (bytes_sent < (p + 1) * PHASE_BYTES) begin
        kind = $urandom_range(99);
        msg = {};
        repeat ($urandom_range(1, 4)) put_field(msg, good_type());
        if (kind < 10) begin
          do wt = 3'($urandom);
          while (wt inside {pbwt_pkg::WT_VARINT, pbwt_pkg::WT_FIXED64,
                            pbwt_pkg::WT_LENGTH, pbwt_pkg::WT_FIXED32});
          put_field(msg, wt);
          put_fixed(msg, {$urandom, $urandom}, $urandom_range(0, 3));
        end else if (kind < 18) begin
          cut = $urandom_range(1, msg.size() - 1);
          while (msg.size() > cut) void'(msg.pop_back());
        end else if (kind < 23) begin
          // overrun the ten-byte varint limit, in a key or in a value
          if ($urandom_range(1)) put_key(msg, $urandom_range(1, 20), pbwt_pkg::WT_VARINT);
          repeat ($urandom_range(10, 12)) msg.push_back(8'h80 | 8'($urandom));
          put_fixed(msg, {$urandom, $urandom}, $urandom_range(0, 2));
        end else if (kind < 30) begin
          msg = {};
          repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
        end
        send_message(msg);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
